// ===== rtl/atan2fx_pkg.sv =====
// Shared constants, types and arithmetic helpers for the fixed-point atan2 core.
package atan2fx_pkg;

   localparam int COORD_WIDTH     = 24;
   localparam int ANGLE_FRAC_BITS = 29;
   localparam int ANGLE_WIDTH     = 32;

   localparam int QF      = 30;                 // internal fraction bits
   localparam int EXT_W   = COORD_WIDTH + 3;    // ratio numerator / denominator
   localparam int CMP_W   = COORD_WIDTH + 6;    // interval compare products
   localparam int QW      = 32;                 // internal Q2.30 word
   localparam int AW      = 34;                 // angle accumulation word
   localparam int QDEPTH  = 4;                  // front/back queue depth
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);
   localparam int POLY_STAGES = 8;
   localparam int ROUND_SH = QF - ANGLE_FRAC_BITS;

   // interval bounds on 16*|y| against k*|x|
   localparam int BOUND_HALF    = 7;
   localparam int BOUND_QUARTER = 11;
   localparam int BOUND_3HALF   = 19;
   localparam int BOUND_VERT    = 39;

   localparam logic signed [AW-1:0] Q30_ATAN_HALF  = 34'sd497837830;
   localparam logic signed [AW-1:0] Q30_QUARTER_PI = 34'sd843314857;
   localparam logic signed [AW-1:0] Q30_ATAN_3HALF = 34'sd1055266725;
   localparam logic signed [AW-1:0] Q30_HALF_PI    = 34'sd1686629713;
   localparam logic signed [AW-1:0] Q30_PI         = 34'sd3373259426;

   localparam logic signed [QW-1:0] POLY_COEF [11] = '{
      32'sd357913941, -32'sd214748365, 32'sd153391689, -32'sd119304639,
      32'sd97612639, -32'sd82590631, 32'sd71520334, -32'sd62623199,
      32'sd53385462, -32'sd39112111, 32'sd17382238
   };

   typedef enum logic [2:0] {
      REG_ZERO    = 3'd0,
      REG_HALF    = 3'd1,
      REG_QUARTER = 3'd2,
      REG_3HALF   = 3'd3,
      REG_VERT    = 3'd4
   } region_type;

   // word handed from the front end through the queue
   typedef struct packed {
      logic signed [EXT_W-1:0] num;
      logic [EXT_W-1:0]        den;
      region_type              region;
      logic                    nx;
      logic                    ny;
      logic                    undef;
   } front_word_type;

   // reduced ratio handed from the divider to the polynomial stages
   typedef struct packed {
      logic signed [QW-1:0] t;
      region_type           region;
      logic                 nx;
      logic                 ny;
      logic                 undef;
   } ratio_word_type;

   // Q30 product, rounded to nearest, ties away from zero
   function automatic logic signed [QW-1:0] qmul(input logic signed [QW-1:0] a,
                                                  input logic signed [QW-1:0] b);
      logic [QW-1:0]   ma;
      logic [QW-1:0]   mb;
      logic [2*QW-1:0] p;
      logic [QW-1:0]   r;
      ma = a[QW-1] ? (~a + QW'(1)) : a;
      mb = b[QW-1] ? (~b + QW'(1)) : b;
      p  = ma * mb + (2*QW)'(64'd1 << (QF - 1));
      r  = p[QF+QW-1:QF];
      return (a[QW-1] ^ b[QW-1]) ? signed'(~r + QW'(1)) : signed'(r);
   endfunction

   function automatic logic signed [AW-1:0] region_offset(input region_type rg);
      logic signed [AW-1:0] off;
      case (rg)
         REG_ZERO:    off = '0;
         REG_HALF:    off = Q30_ATAN_HALF;
         REG_QUARTER: off = Q30_QUARTER_PI;
         REG_3HALF:   off = Q30_ATAN_3HALF;
         REG_VERT:    off = Q30_HALF_PI;
         default:     off = '0;
      endcase
      return off;
   endfunction

endpackage

// ===== rtl/atan2fx_if.sv =====
// Valid/ready channel interfaces for coordinate requests and angle responses.
interface atan2fx_req_if;
   logic                                        valid;
   logic                                        ready;
   logic signed [atan2fx_pkg::COORD_WIDTH-1:0] x_coord;
   logic signed [atan2fx_pkg::COORD_WIDTH-1:0] y_coord;
   modport source(output valid, output x_coord, output y_coord, input ready);
   modport sink(input valid, input x_coord, input y_coord, output ready);
endinterface

interface atan2fx_rsp_if;
   logic                                        valid;
   logic                                        ready;
   logic signed [atan2fx_pkg::ANGLE_WIDTH-1:0] angle;
   logic                                        undefined;
   modport source(output valid, output angle, output undefined, input ready);
   modport sink(input valid, input angle, input undefined, output ready);
endinterface

// ===== rtl/atan2_fixed_point_core.sv =====
// Top level of the fixed-point four-quadrant arctangent core.
// Usage:
//   req_chan carries one coordinate pair (x_coord, y_coord), 24-bit two's
//   complement integers; a word is taken when valid and ready are both high.
//   rsp_chan returns angle, Q3.29 radians in (-pi, pi], and undefined, set
//   (with angle 0) when both coordinates are zero. Results leave in order.
// Timing:
//   One word is accepted per clock while the queue is not full. From
//   acceptance to rsp valid a word passes the queue register, then 31 divider
//   stages (a load stage and 30 quotient bits), 8 polynomial stages and the
//   output register.
// Stall:
//   While rsp is valid and not ready the whole back pipeline holds; the
//   front queue (4 words) keeps accepting until it fills, then req.ready
//   drops. No word is dropped or repeated.
// Reset:
//   Synchronous, active high; empties the queue and clears all valid bits.
//   Payload registers are not cleared.
module atan2_fixed_point_core (
   input  logic          clock,
   input  logic          reset,
   atan2fx_req_if.sink   req_chan,
   atan2fx_rsp_if.source rsp_chan
);
   atan2fx_pkg::front_word_type front_word;
   atan2fx_pkg::front_word_type head_word;
   atan2fx_pkg::ratio_word_type ratio_word;
   logic push;
   logic pop;
   logic not_empty;
   logic not_full;
   logic advance;
   logic ratio_valid;
   logic out_valid;

   assign advance        = !out_valid || rsp_chan.ready;
   assign req_chan.ready = not_full;
   assign push           = req_chan.valid && not_full;
   assign pop            = advance && not_empty;

   atan2fx_front u_front (
      .x_coord (req_chan.x_coord),
      .y_coord (req_chan.y_coord),
      .word    (front_word)
   );

   atan2fx_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (front_word),
      .pop       (pop),
      .head_word (head_word),
      .not_empty (not_empty),
      .not_full  (not_full)
   );

   atan2fx_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (not_empty),
      .in_word   (head_word),
      .out_valid (ratio_valid),
      .out_word  (ratio_word)
   );

   atan2fx_poly u_poly (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .in_valid      (ratio_valid),
      .in_word       (ratio_word),
      .out_valid     (out_valid),
      .out_angle     (rsp_chan.angle),
      .out_undefined (rsp_chan.undefined)
   );

   assign rsp_chan.valid = out_valid;

endmodule

// ===== rtl/atan2fx_front.sv =====
// Front end: folds coordinate signs and picks the reduction interval and ratio terms.
module atan2fx_front (
   input  logic signed [atan2fx_pkg::COORD_WIDTH-1:0] x_coord,
   input  logic signed [atan2fx_pkg::COORD_WIDTH-1:0] y_coord,
   output atan2fx_pkg::front_word_type                 word
);
   localparam int W  = atan2fx_pkg::COORD_WIDTH;
   localparam int EW = atan2fx_pkg::EXT_W;
   localparam int CW = atan2fx_pkg::CMP_W;

   logic [W-1:0]         ax;
   logic [W-1:0]         ay;
   logic [CW-1:0]        y16;
   logic signed [EW-1:0] sx;
   logic signed [EW-1:0] sy;
   logic signed [EW-1:0] num;
   logic signed [EW-1:0] den;
   atan2fx_pkg::region_type region;

   // most negative input maps to 2^(W-1) exactly in W unsigned bits
   assign ax  = x_coord[W-1] ? (~x_coord + W'(1)) : x_coord;
   assign ay  = y_coord[W-1] ? (~y_coord + W'(1)) : y_coord;
   assign y16 = CW'(ay) << 4;
   assign sx  = signed'(EW'(ax));
   assign sy  = signed'(EW'(ay));

   always_comb begin
      if (y16 < CW'(ax) * CW'(atan2fx_pkg::BOUND_VERT)) begin
         if (y16 < CW'(ax) * CW'(atan2fx_pkg::BOUND_HALF)) begin
            num    = sy;
            den    = sx;
            region = atan2fx_pkg::REG_ZERO;
         end else if (y16 < CW'(ax) * CW'(atan2fx_pkg::BOUND_QUARTER)) begin
            num    = (sy <<< 1) - sx;
            den    = (sx <<< 1) + sy;
            region = atan2fx_pkg::REG_HALF;
         end else if (y16 < CW'(ax) * CW'(atan2fx_pkg::BOUND_3HALF)) begin
            num    = sy - sx;
            den    = sx + sy;
            region = atan2fx_pkg::REG_QUARTER;
         end else begin
            num    = (sy <<< 1) - sx - (sx <<< 1);
            den    = (sx <<< 1) + sy + (sy <<< 1);
            region = atan2fx_pkg::REG_3HALF;
         end
      end else begin
         num    = -sx;
         den    = sy;
         region = atan2fx_pkg::REG_VERT;
      end
   end

   assign word.num    = num;
   assign word.den    = unsigned'(den);
   assign word.region = region;
   assign word.nx     = x_coord[W-1];
   assign word.ny     = y_coord[W-1];
   assign word.undef  = (ax == '0) && (ay == '0);

endmodule

// ===== rtl/atan2fx_queue.sv =====
// Short register queue between the front end and the arithmetic pipeline.
module atan2fx_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  atan2fx_pkg::front_word_type push_word,
   input  logic                        pop,
   output atan2fx_pkg::front_word_type head_word,
   output logic                        not_empty,
   output logic                        not_full
);
   localparam int PW = atan2fx_pkg::QPTR_W;
   localparam int CW = atan2fx_pkg::QCNT_W;

   atan2fx_pkg::front_word_type slot_ff [atan2fx_pkg::QDEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign not_empty = (count_ff != '0);
   assign not_full  = (count_ff != CW'(atan2fx_pkg::QDEPTH));
   assign head_word = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// ===== rtl/atan2fx_div.sv =====
// Pipelined restoring divider: one quotient bit per stage gives the Q30 reduced ratio.
module atan2fx_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        in_valid,
   input  atan2fx_pkg::front_word_type in_word,
   output logic                        out_valid,
   output atan2fx_pkg::ratio_word_type out_word
);
   localparam int EW = atan2fx_pkg::EXT_W;
   localparam int QF = atan2fx_pkg::QF;
   localparam int QW = atan2fx_pkg::QW;

   typedef struct packed {
      logic [EW-1:0]           rem;
      logic [QF-1:0]           low;
      logic [QF-1:0]           quo;
      logic [EW-1:0]           den;
      logic                    nneg;
      atan2fx_pkg::region_type region;
      logic                    nx;
      logic                    ny;
      logic                    undef;
   } div_stage_type;

   div_stage_type stage_ff [QF+1];
   logic          valid_ff [QF+1];
   div_stage_type first_in;
   logic [EW-1:0]    mag;
   logic [EW+QF-1:0] dividend;

   function automatic div_stage_type div_step(input div_stage_type s);
      div_stage_type n;
      logic [EW:0]   trial;
      logic [EW:0]   diff;
      logic          ge;
      n     = s;
      trial = {s.rem, s.low[QF-1]};
      diff  = trial - {1'b0, s.den};
      ge    = (trial >= {1'b0, s.den});
      n.rem = ge ? diff[EW-1:0] : trial[EW-1:0];
      n.quo = {s.quo[QF-2:0], ge};
      n.low = {s.low[QF-2:0], 1'b0};
      return n;
   endfunction

   // dividend = |num| * 2^30 + den/2, upper part already below den
   always_comb begin
      mag             = in_word.num[EW-1] ? (~in_word.num + EW'(1)) : in_word.num;
      dividend        = {mag, {QF{1'b0}}} + (EW+QF)'(in_word.den >> 1);
      first_in.rem    = dividend[EW+QF-1:QF];
      first_in.low    = dividend[QF-1:0];
      first_in.quo    = '0;
      first_in.den    = in_word.den;
      first_in.nneg   = in_word.num[EW-1];
      first_in.region = in_word.region;
      first_in.nx     = in_word.nx;
      first_in.ny     = in_word.ny;
      first_in.undef  = in_word.undef;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= QF; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i <= QF; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff[0] <= first_in;
         for (int i = 1; i <= QF; i++) begin
            stage_ff[i] <= div_step(stage_ff[i-1]);
         end
      end
   end

   assign out_valid       = valid_ff[QF];
   assign out_word.t      = stage_ff[QF].nneg ? -signed'(QW'(stage_ff[QF].quo))
                                              : signed'(QW'(stage_ff[QF].quo));
   assign out_word.region = stage_ff[QF].region;
   assign out_word.nx     = stage_ff[QF].nx;
   assign out_word.ny     = stage_ff[QF].ny;
   assign out_word.undef  = stage_ff[QF].undef;

endmodule

// ===== rtl/atan2fx_poly.sv =====
// Polynomial stages, quadrant restore, rounding and the response output register.
module atan2fx_poly (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        advance,
   input  logic                                        in_valid,
   input  atan2fx_pkg::ratio_word_type                 in_word,
   output logic                                        out_valid,
   output logic signed [atan2fx_pkg::ANGLE_WIDTH-1:0] out_angle,
   output logic                                        out_undefined
);
   localparam int QW = atan2fx_pkg::QW;
   localparam int AW = atan2fx_pkg::AW;
   localparam int NS = atan2fx_pkg::POLY_STAGES;
   localparam int SH = atan2fx_pkg::ROUND_SH;
   localparam logic [AW-1:0] RND = (SH == 0) ? '0 : AW'(1) << ((SH == 0) ? 0 : SH - 1);

   typedef struct packed {
      logic signed [QW-1:0]    t;
      logic signed [QW-1:0]    z;
      logic signed [QW-1:0]    z2;
      logic signed [QW-1:0]    z4;
      logic signed [QW-1:0]    tz;
      logic signed [QW-1:0]    hi;   // high Horner sum, finally t*z*p
      logic signed [QW-1:0]    lo;   // low Horner sum, finally p
      atan2fx_pkg::region_type region;
      logic                    nx;
      logic                    ny;
      logic                    undef;
   } poly_stage_type;

   poly_stage_type stage_ff [NS];
   logic           valid_ff [NS];
   poly_stage_type first_in;
   logic                 out_valid_ff;
   logic signed [QW-1:0] angle_ff, angle_in;
   logic                 undef_ff;
   logic signed [AW-1:0] ang;
   logic signed [AW-1:0] clamped;
   logic [AW-1:0]        folded;
   logic [AW-1:0]        rounded;

   function automatic poly_stage_type poly_step(input int k, input poly_stage_type s);
      poly_stage_type n;
      n = s;
      case (k)
         1: begin
            n.z2 = atan2fx_pkg::qmul(s.z, s.z);
            n.tz = atan2fx_pkg::qmul(s.t, s.z);
            n.hi = atan2fx_pkg::POLY_COEF[9] + atan2fx_pkg::qmul(s.z, atan2fx_pkg::POLY_COEF[10]);
            n.lo = atan2fx_pkg::POLY_COEF[3] + atan2fx_pkg::qmul(s.z, atan2fx_pkg::POLY_COEF[4]);
         end
         2: begin
            n.z4 = atan2fx_pkg::qmul(s.z2, s.z2);
            n.hi = atan2fx_pkg::POLY_COEF[8] + atan2fx_pkg::qmul(s.z, s.hi);
            n.lo = atan2fx_pkg::POLY_COEF[2] + atan2fx_pkg::qmul(s.z, s.lo);
         end
         3: begin
            n.hi = atan2fx_pkg::POLY_COEF[7] + atan2fx_pkg::qmul(s.z, s.hi);
            n.lo = atan2fx_pkg::POLY_COEF[1] + atan2fx_pkg::qmul(s.z, s.lo);
         end
         4: begin
            n.hi = atan2fx_pkg::POLY_COEF[6] + atan2fx_pkg::qmul(s.z, s.hi);
            n.lo = atan2fx_pkg::qmul(s.z, s.lo);
         end
         5: begin
            n.hi = atan2fx_pkg::POLY_COEF[5] + atan2fx_pkg::qmul(s.z, s.hi);
         end
         6: begin
            n.lo = atan2fx_pkg::POLY_COEF[0] + s.lo + atan2fx_pkg::qmul(s.z4, s.hi);
         end
         7: begin
            n.hi = atan2fx_pkg::qmul(s.tz, s.lo);
         end
         default: begin
            n = s;
         end
      endcase
      return n;
   endfunction

   always_comb begin
      first_in        = '0;
      first_in.t      = in_word.t;
      first_in.z      = atan2fx_pkg::qmul(in_word.t, in_word.t);
      first_in.region = in_word.region;
      first_in.nx     = in_word.nx;
      first_in.ny     = in_word.ny;
      first_in.undef  = in_word.undef;
   end

   // angle = offset + t - t*z*p, clamped to [0, pi], mirrored for negative x, negated for negative y
   always_comb begin
      ang = atan2fx_pkg::region_offset(stage_ff[NS-1].region)
            + AW'(stage_ff[NS-1].t) - AW'(stage_ff[NS-1].hi);
      if (ang < 0) begin
         clamped = '0;
      end else if (ang > atan2fx_pkg::Q30_PI) begin
         clamped = atan2fx_pkg::Q30_PI;
      end else begin
         clamped = ang;
      end
      folded   = unsigned'(stage_ff[NS-1].nx ? atan2fx_pkg::Q30_PI - clamped : clamped);
      rounded  = (folded + RND) >> SH;
      angle_in = stage_ff[NS-1].ny ? -signed'(rounded[QW-1:0]) : signed'(rounded[QW-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NS; i++) begin
            valid_ff[i] <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i < NS; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
         out_valid_ff <= valid_ff[NS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff[0] <= first_in;
         for (int i = 1; i < NS; i++) begin
            stage_ff[i] <= poly_step(i, stage_ff[i-1]);
         end
         angle_ff <= stage_ff[NS-1].undef ? '0 : angle_in;
         undef_ff <= stage_ff[NS-1].undef;
      end
   end

   assign out_valid     = out_valid_ff;
   assign out_angle     = angle_ff;
   assign out_undefined = undef_ff;

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the fixed-point atan2 core: directed table, then random vectors.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [atan2fx_pkg::COORD_WIDTH-1:0] coord_type;

   typedef struct {
      logic signed [atan2fx_pkg::ANGLE_WIDTH-1:0] angle;
      logic                                       undefined;
   } angle_word_type;

   typedef struct {
      coord_type                                  x;
      coord_type                                  y;
      bit                                         known;
      logic signed [atan2fx_pkg::ANGLE_WIDTH-1:0] angle;
      logic                                       undefined;
   } vector_row_type;

   localparam int STALL_LIMIT = 3000;
   localparam int N_RANDOM    = 950;
   localparam int CALM_TAIL   = 150;

   logic clock;
   logic reset;
   atan2fx_req_if req_bus();
   atan2fx_rsp_if rsp_bus();

   atan2_fixed_point_core dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus)
   );

   angle_word_type pending_angles[$];
   int          error_count;
   int          words_sent;
   int          words_checked;
   int          undefined_seen;
   int          idle_cycles;
   bit          idling_on;
   bit          row_known;
   logic signed [atan2fx_pkg::ANGLE_WIDTH-1:0] row_angle;
   logic        row_undefined;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.x_coord = '0;
      req_bus.y_coord = '0;
      rsp_bus.ready = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Q30 product, round to nearest, ties away from zero
   function automatic longint q30_product(input longint a, input longint b);
      longint unsigned ma, mb, pr;
      ma = (a < 0) ? longint'(-a) : a;
      mb = (b < 0) ? longint'(-b) : b;
      pr = (ma * mb + (64'd1 << 29)) >> 30;
      return ((a < 0) != (b < 0)) ? -longint'(pr) : longint'(pr);
   endfunction

   function automatic longint q30_ratio(input longint num, input longint den);
      longint unsigned mag, q;
      mag = (num < 0) ? -num : num;
      q = ((mag << 30) + longint'(den) / 2) / den;
      return (num < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic angle_word_type vector_angle(input coord_type xc, input coord_type yc);
      angle_word_type res;
      longint ax, ay, t, off, z, z2, lowp, highp, p, ang;
      longint unsigned m, r;
      int sh;
      ax = (xc < 0) ? -longint'(xc) : longint'(xc);
      ay = (yc < 0) ? -longint'(yc) : longint'(yc);
      res.angle = '0;
      res.undefined = 1'b0;
      if (ax == 0 && ay == 0) begin
         res.undefined = 1'b1;
         return res;
      end
      if (16 * ay < 39 * ax) begin
         if (16 * ay < 7 * ax) begin
            t = q30_ratio(ay, ax);
            off = 0;
         end else if (16 * ay < 11 * ax) begin
            t = q30_ratio(2 * ay - ax, 2 * ax + ay);
            off = longint'(atan2fx_pkg::Q30_ATAN_HALF);
         end else if (16 * ay < 19 * ax) begin
            t = q30_ratio(ay - ax, ax + ay);
            off = longint'(atan2fx_pkg::Q30_QUARTER_PI);
         end else begin
            t = q30_ratio(2 * ay - 3 * ax, 2 * ax + 3 * ay);
            off = longint'(atan2fx_pkg::Q30_ATAN_3HALF);
         end
      end else begin
         t = q30_ratio(-ax, ay);
         off = longint'(atan2fx_pkg::Q30_HALF_PI);
      end
      z = q30_product(t, t);
      z2 = q30_product(z, z);
      lowp = longint'(atan2fx_pkg::POLY_COEF[4]);
      for (int i = 3; i >= 1; i--)
         lowp = longint'(atan2fx_pkg::POLY_COEF[i]) + q30_product(z, lowp);
      highp = longint'(atan2fx_pkg::POLY_COEF[10]);
      for (int i = 9; i >= 5; i--)
         highp = longint'(atan2fx_pkg::POLY_COEF[i]) + q30_product(z, highp);
      p = longint'(atan2fx_pkg::POLY_COEF[0]) + q30_product(z, lowp)
          + q30_product(q30_product(z2, z2), highp);
      ang = off + t - q30_product(q30_product(t, z), p);
      if (ang < 0) ang = 0;
      if (ang > longint'(atan2fx_pkg::Q30_PI)) ang = longint'(atan2fx_pkg::Q30_PI);
      if (xc < 0) ang = longint'(atan2fx_pkg::Q30_PI) - ang;
      sh = 30 - atan2fx_pkg::ANGLE_FRAC_BITS;
      m = ang;
      r = (sh == 0) ? m : ((m + (64'd1 << (sh - 1))) >> sh);
      if (yc < 0) r = -r;
      res.angle = r[atan2fx_pkg::ANGLE_WIDTH-1:0];
      return res;
   endfunction

   // request monitor: log expectation for every accepted word
   always @(posedge clock) begin
      angle_word_type e;
      if (!reset && req_bus.valid && req_bus.ready) begin
         if (row_known) begin
            e.angle = row_angle;
            e.undefined = row_undefined;
         end else begin
            e = vector_angle(req_bus.x_coord, req_bus.y_coord);
         end
         pending_angles.push_back(e);
         words_sent++;
      end
   end

   // response checker
   always @(posedge clock) begin
      angle_word_type e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_angles.size() == 0) begin
            report_mismatch($sformatf("unexpected word angle=%0d undefined=%b",
                                      rsp_bus.angle, rsp_bus.undefined));
         end else begin
            e = pending_angles.pop_front();
            words_checked++;
            if (rsp_bus.undefined) undefined_seen++;
            if (rsp_bus.angle !== e.angle)
               report_mismatch($sformatf("angle got %0d exp %0d", rsp_bus.angle, e.angle));
            if (rsp_bus.undefined !== e.undefined)
               report_mismatch($sformatf("undefined got %b exp %b",
                                         rsp_bus.undefined, e.undefined));
         end
      end
   end

   // watchdog: cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Watchdog expired, %0d words outstanding", pending_angles.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // response back-pressure in bursts
   initial begin
      int n;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         rsp_bus.ready = 1'b1;
         n = $urandom_range(1, 12);
         repeat (n) @(negedge clock);
         if (idling_on && $urandom_range(0, 2) == 0) begin
            rsp_bus.ready = 1'b0;
            n = $urandom_range(1, 4);
            repeat (n) @(negedge clock);
         end
      end
   end

   task automatic send_vector(input coord_type xc, input coord_type yc);
      int n;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid = 1'b0;
         n = $urandom_range(1, 4);
         repeat (n) @(negedge clock);
      end
      req_bus.x_coord = xc;
      req_bus.y_coord = yc;
      req_bus.valid = 1'b1;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic coord_type random_coord(input int kind, input longint mag_in);
      longint mag;
      mag = mag_in;
      if (mag > 8388607) mag = 8388607;
      if (mag < 0) mag = 0;
      case (kind)
         0: return coord_type'($urandom());
         default: return ($urandom_range(0, 1) != 0) ? coord_type'(-mag) : coord_type'(mag);
      endcase
   endfunction

   initial begin
      vector_row_type rows[$];
      vector_row_type row;
      int k[4];
      longint ax, ay;
      int mode;
      coord_type xc, yc;
      k = '{7, 11, 19, 39};
      error_count = 0;
      words_sent = 0;
      words_checked = 0;
      undefined_seen = 0;
      row_known = 1'b0;
      row_angle = '0;
      row_undefined = 1'b0;
      idling_on = 1'b1;
      // directed table: known = typed expectation, else predictor
      rows.push_back('{24'sd0, 24'sd0, 1, 32'sd0, 1'b1});
      rows.push_back('{24'sd1, 24'sd0, 1, 32'sd0, 1'b0});
      rows.push_back('{24'sd0, 24'sd1, 1, 32'sd843314857, 1'b0});
      rows.push_back('{24'sd0, -24'sd1, 1, -32'sd843314857, 1'b0});
      rows.push_back('{-24'sd1, 24'sd0, 1, 32'sd1686629713, 1'b0});
      rows.push_back('{-24'sd8388608, 24'sd0, 1, 32'sd1686629713, 1'b0});
      rows.push_back('{24'sd0, -24'sd8388608, 1, -32'sd843314857, 1'b0});
      rows.push_back('{24'sd8388607, 24'sd0, 1, 32'sd0, 1'b0});
      rows.push_back('{-24'sd8388608, -24'sd8388608, 0, 0, 0});
      rows.push_back('{24'sd8388607, -24'sd8388608, 0, 0, 0});
      rows.push_back('{-24'sd8388608, 24'sd8388607, 0, 0, 0});
      rows.push_back('{24'sd8388607, 24'sd8388607, 0, 0, 0});
      rows.push_back('{24'sd16, 24'sd6, 0, 0, 0});
      rows.push_back('{24'sd16, 24'sd7, 0, 0, 0});
      rows.push_back('{24'sd16, 24'sd10, 0, 0, 0});
      rows.push_back('{24'sd16, 24'sd11, 0, 0, 0});
      rows.push_back('{-24'sd16, 24'sd18, 0, 0, 0});
      rows.push_back('{24'sd16, -24'sd19, 0, 0, 0});
      rows.push_back('{-24'sd16, -24'sd38, 0, 0, 0});
      rows.push_back('{24'sd16, 24'sd39, 0, 0, 0});
      rows.push_back('{-24'sd3, 24'sd5, 0, 0, 0});
      rows.push_back('{24'sd1, -24'sd8388608, 0, 0, 0});
      @(negedge clock);
      while (reset) @(negedge clock);
      foreach (rows[i]) begin
         row = rows[i];
         row_known = row.known;
         row_angle = row.angle;
         row_undefined = row.undefined;
         send_vector(row.x, row.y);
      end
      row_known = 1'b0;
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i >= N_RANDOM - CALM_TAIL) idling_on = 1'b0;
         mode = $urandom_range(0, 9);
         if (mode < 4) begin
            xc = random_coord(0, 0);
            yc = random_coord(0, 0);
         end else if (mode < 7) begin
            // straddle an interval boundary
            ax = $urandom_range(1, ($urandom_range(0, 1) != 0) ? 200 : 400000);
            ay = (k[$urandom_range(0, 3)] * ax) / 16 + longint'($urandom_range(0, 2)) - 1;
            xc = random_coord(1, ax);
            yc = random_coord(1, ay);
         end else if (mode < 9) begin
            xc = random_coord(1, $urandom_range(0, 64));
            yc = random_coord(1, $urandom_range(0, 64));
         end else begin
            // on an axis, zero vector, or most negative value
            case ($urandom_range(0, 3))
               0: begin xc = '0; yc = random_coord(0, 0); end
               1: begin xc = random_coord(0, 0); yc = '0; end
               2: begin xc = '0; yc = '0; end
               default: begin
                  xc = {1'b1, {(atan2fx_pkg::COORD_WIDTH-1){1'b0}}};
                  yc = random_coord(0, 0);
               end
            endcase
         end
         send_vector(xc, yc);
      end
      req_bus.valid = 1'b0;
      while (pending_angles.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("Covered %0d vectors (%0d checked, %0d zero vectors) over all quadrants,",
               words_sent, words_checked, undefined_seen);
      $display("interval boundaries and coordinate extremes, with random stalls on both sides.");
      if (error_count == 0 && pending_angles.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/atan2fx_pkg.sv
rtl/atan2fx_if.sv
rtl/atan2fx_front.sv
rtl/atan2fx_queue.sv
rtl/atan2fx_div.sv
rtl/atan2fx_poly.sv
rtl/atan2_fixed_point_core.sv
sim/testbench.sv
